### rtl/assert_macros.svh
// Assertion helpers; every use samples on clk_i and is off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TMAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define TMAC_ASSERT_IMPL(lbl, pre, post, msg) \
  `TMAC_ASSERT(lbl, (pre) |-> (post), msg)

`define TMAC_ASSERT_NEXT(lbl, pre, post, msg) \
  `TMAC_ASSERT(lbl, (pre) |=> (post), msg)

`endif

### rtl/tmac_pkg.sv
package tmac_pkg;

  // result word: unsigned Q1.16 with room for 1.0
  localparam int unsigned CosW     = 17;
  localparam int unsigned RootBits = 17;
  localparam logic [CosW-1:0] OneQ16 = 17'd65536;
  localparam logic [4:0]      RootTop = 5'd16;

endpackage

### rtl/triangle_max_angle_cosine.sv
// Largest absolute corner cosine over a group of triangles. Each input word
// carries one triangle (three signed vertices, COORD_BITS per coordinate) and
// a group_end flag; a result word (unsigned Q1.16, 65536 = 1.0) comes out only
// on the word marked group_end, after which the running maximum clears. A
// corner with a zero-length edge is skipped; a group with no usable corner
// gives 0. For each triangle the back end runs the three squared edge lengths
// and three dot products through the shared multiplier, then for each corner a
// check, the partial products for the wide norm product and dot square, and 17
// steps of the bit-serial root search; a skipped corner ends at its check. A
// two-word queue sits between the edge front end and the back end, and the
// result register frees the back end to start the next triangle while a word
// waits downstream.
module triangle_max_angle_cosine #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [COORD_BITS-1:0]  ax_i,
  input  logic signed [COORD_BITS-1:0]  ay_i,
  input  logic signed [COORD_BITS-1:0]  az_i,
  input  logic signed [COORD_BITS-1:0]  bx_i,
  input  logic signed [COORD_BITS-1:0]  by_i,
  input  logic signed [COORD_BITS-1:0]  bz_i,
  input  logic signed [COORD_BITS-1:0]  cx_i,
  input  logic signed [COORD_BITS-1:0]  cy_i,
  input  logic signed [COORD_BITS-1:0]  cz_i,
  input  logic                          group_end_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tmac_pkg::CosW-1:0]     max_cosine_o
);

  // edge word: nine (COORD_BITS+1)-bit components plus group_end
  localparam int unsigned QWidth = 9 * (COORD_BITS + 1) + 1;

  logic              full, push, q_valid, q_pop;
  logic [QWidth-1:0] f_data, q_data;

  tmac_front #(.CoordBits(COORD_BITS)) u_front (
    .ax_i, .ay_i, .az_i, .bx_i, .by_i, .bz_i, .cx_i, .cy_i, .cz_i,
    .group_end_i,
    .in_valid_i,
    .in_stall_o,
    .full_i (full),
    .push_o (push),
    .data_o (f_data)
  );

  tmac_queue #(.Width(QWidth)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (f_data),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_data)
  );

  tmac_back #(.CoordBits(COORD_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_valid_o,
    .out_stall_i,
    .max_cosine_o
  );

endmodule

### rtl/tmac_front.sv
module tmac_front #(
  parameter int unsigned CoordBits = 16
) (
  input  logic signed [CoordBits-1:0] ax_i,
  input  logic signed [CoordBits-1:0] ay_i,
  input  logic signed [CoordBits-1:0] az_i,
  input  logic signed [CoordBits-1:0] bx_i,
  input  logic signed [CoordBits-1:0] by_i,
  input  logic signed [CoordBits-1:0] bz_i,
  input  logic signed [CoordBits-1:0] cx_i,
  input  logic signed [CoordBits-1:0] cy_i,
  input  logic signed [CoordBits-1:0] cz_i,
  input  logic                        group_end_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        full_i,
  output logic                        push_o,
  output logic [9*(CoordBits+1):0]    data_o
);

  localparam int unsigned E = CoordBits + 1;

  logic signed [E-1:0] l1x, l1y, l1z, l2x, l2y, l2z, l3x, l3y, l3z;

  // edge vectors l1 = B - A, l2 = C - B, l3 = A - C
  assign l1x = E'(bx_i) - E'(ax_i);
  assign l1y = E'(by_i) - E'(ay_i);
  assign l1z = E'(bz_i) - E'(az_i);
  assign l2x = E'(cx_i) - E'(bx_i);
  assign l2y = E'(cy_i) - E'(by_i);
  assign l2z = E'(cz_i) - E'(bz_i);
  assign l3x = E'(ax_i) - E'(cx_i);
  assign l3y = E'(ay_i) - E'(cy_i);
  assign l3z = E'(az_i) - E'(cz_i);

  assign data_o = {group_end_i, l3z, l3y, l3x, l2z, l2y, l2x, l1z, l1y, l1x};

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

endmodule

### rtl/tmac_queue.sv
module tmac_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

endmodule

### rtl/tmac_back.sv
`include "assert_macros.svh"

module tmac_back #(
  parameter int unsigned CoordBits = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  logic [9*(CoordBits+1):0]     q_data_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tmac_pkg::CosW-1:0]    max_cosine_o
);

  localparam int unsigned E  = CoordBits + 1;
  localparam int unsigned H  = E + 1;
  localparam int unsigned SW = 2 * H;
  localparam int unsigned DW = 4 * H;
  localparam int unsigned NW = DW + 36;
  localparam int unsigned QW = DW + 17;
  localparam int unsigned CW = tmac_pkg::CosW;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMul   = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StDen   = 3'd3;
  localparam logic [2:0] StNum   = 3'd4;
  localparam logic [2:0] StRoot  = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0]   state_q, state_d;
  logic [2:0]   grp_q, grp_d;
  logic [1:0]   cmp_q, cmp_d;
  logic [1:0]   pp_q, pp_d;
  logic [1:0]   corner_q, corner_d;
  logic [4:0]   bit_q, bit_d;
  logic         gend_q;
  logic signed [E-1:0]  edge_q [9];
  logic signed [SW-1:0] s_q [6];
  logic [DW-1:0] den_q, sq_q;
  logic [NW-1:0] p_q;
  logic [QW-1:0] qd_q;
  logic [tmac_pkg::RootBits-1:0] root_q;
  logic [CW-1:0] run_max_q, max_cos_q;
  logic          out_valid_q;

  // operand selection
  logic [1:0] ia, ib;
  logic [3:0] ea_idx, eb_idx;
  logic [2:0] nu_idx, nv_idx, dot_idx;
  logic [SW-1:0] nu, nv, adot, xw, yw;
  logic [H-1:0]  xh, yh;
  logic signed [H:0]     mul_a, mul_b;
  logic signed [2*H+1:0] prod;
  logic [DW-1:0] pp_ext, pp_sh;

  // root step
  logic [NW-1:0] num_w, cand;
  logic          take, out_free;
  logic [tmac_pkg::RootBits-1:0] root_try, root_fin;
  logic [CW-1:0] root_sat;

  always_comb begin
    unique case (grp_q)
      3'd0:    begin ia = 2'd0; ib = 2'd0; end
      3'd1:    begin ia = 2'd1; ib = 2'd1; end
      3'd2:    begin ia = 2'd2; ib = 2'd2; end
      3'd3:    begin ia = 2'd0; ib = 2'd2; end
      3'd4:    begin ia = 2'd0; ib = 2'd1; end
      default: begin ia = 2'd1; ib = 2'd2; end
    endcase
    // corner A: l1,l3; B: l1,l2; C: l2,l3
    unique case (corner_q)
      2'd0:    begin nu_idx = 3'd0; nv_idx = 3'd2; dot_idx = 3'd3; end
      2'd1:    begin nu_idx = 3'd0; nv_idx = 3'd1; dot_idx = 3'd4; end
      default: begin nu_idx = 3'd1; nv_idx = 3'd2; dot_idx = 3'd5; end
    endcase
  end

  assign ea_idx = ({2'b0, ia} * 4'd3) + {2'b0, cmp_q};
  assign eb_idx = ({2'b0, ib} * 4'd3) + {2'b0, cmp_q};
  assign nu     = s_q[nu_idx];
  assign nv     = s_q[nv_idx];
  assign adot   = s_q[dot_idx][SW-1] ? SW'(-s_q[dot_idx]) : s_q[dot_idx];
  assign xw     = (state_q == StNum) ? adot : nu;
  assign yw     = (state_q == StNum) ? adot : nv;
  assign xh     = pp_q[0] ? xw[SW-1:H] : xw[H-1:0];
  assign yh     = pp_q[1] ? yw[SW-1:H] : yw[H-1:0];

  always_comb begin
    if (state_q == StMul) begin
      mul_a = {{2{edge_q[ea_idx][E-1]}}, edge_q[ea_idx]};
      mul_b = {{2{edge_q[eb_idx][E-1]}}, edge_q[eb_idx]};
    end else begin
      mul_a = {1'b0, xh};
      mul_b = {1'b0, yh};
    end
  end

  assign prod   = mul_a * mul_b;
  assign pp_ext = DW'(prod[SW-1:0]);

  always_comb begin
    case ({1'b0, pp_q[0]} + {1'b0, pp_q[1]})
      2'd0:    pp_sh = pp_ext;
      2'd1:    pp_sh = pp_ext << H;
      default: pp_sh = pp_ext << (2 * H);
    endcase
  end

  // try next bit: (q + 2^b)^2 * den = P + (q*den) << (b+1) + den << 2b
  assign num_w    = {4'b0, sq_q, 32'b0};
  assign cand     = p_q + (NW'(qd_q) << (bit_q + 5'd1)) + (NW'(den_q) << {bit_q, 1'b0});
  assign take     = cand <= num_w;
  assign root_try = root_q | (tmac_pkg::RootBits'(1) << bit_q);
  assign root_fin = take ? root_try : root_q;
  assign root_sat = (root_fin > tmac_pkg::OneQ16) ? tmac_pkg::OneQ16 : root_fin;
  assign out_free = ~out_valid_q | ~out_stall_i;

  assign q_pop_o = (state_q == StIdle) & q_valid_i;

  always_comb begin
    state_d  = state_q;
    grp_d    = grp_q;
    cmp_d    = cmp_q;
    pp_d     = pp_q;
    corner_d = corner_q;
    bit_d    = bit_q;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          grp_d   = 3'd0;
          cmp_d   = 2'd0;
          state_d = StMul;
        end
      end
      StMul: begin
        if (cmp_q == 2'd2) begin
          cmp_d = 2'd0;
          grp_d = grp_q + 3'd1;
          if (grp_q == 3'd5) begin
            corner_d = 2'd0;
            state_d  = StCheck;
          end
        end else begin
          cmp_d = cmp_q + 2'd1;
        end
      end
      StCheck: begin
        if (nu == '0 || nv == '0) begin
          if (corner_q == 2'd2) state_d = StDone;
          else corner_d = corner_q + 2'd1;
        end else begin
          pp_d    = 2'd0;
          state_d = StDen;
        end
      end
      StDen: begin
        pp_d = pp_q + 2'd1;
        if (pp_q == 2'd3) state_d = StNum;
      end
      StNum: begin
        pp_d = pp_q + 2'd1;
        if (pp_q == 2'd3) begin
          bit_d   = tmac_pkg::RootTop;
          state_d = StRoot;
        end
      end
      StRoot: begin
        if (bit_q == 5'd0) begin
          if (corner_q == 2'd2) begin
            state_d = StDone;
          end else begin
            corner_d = corner_q + 2'd1;
            state_d  = StCheck;
          end
        end else begin
          bit_d = bit_q - 5'd1;
        end
      end
      StDone: begin
        if (!gend_q || out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      grp_q       <= 3'd0;
      cmp_q       <= 2'd0;
      pp_q        <= 2'd0;
      corner_q    <= 2'd0;
      bit_q       <= 5'd0;
      run_max_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      grp_q    <= grp_d;
      cmp_q    <= cmp_d;
      pp_q     <= pp_d;
      corner_q <= corner_d;
      bit_q    <= bit_d;
      if (state_q == StRoot && bit_q == 5'd0 && root_sat > run_max_q) run_max_q <= root_sat;
      if (state_q == StDone && gend_q && out_free) begin
        out_valid_q <= 1'b1;
        run_max_q   <= '0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      for (int k = 0; k < 9; k++) edge_q[k] <= q_data_i[k*E +: E];
      gend_q <= q_data_i[9*E];
    end
    if (state_q == StMul) begin
      s_q[grp_q] <= (cmp_q == 2'd0) ? prod[SW-1:0] : s_q[grp_q] + prod[SW-1:0];
    end
    if (state_q == StDen) den_q <= (pp_q == 2'd0) ? pp_sh : den_q + pp_sh;
    if (state_q == StNum) sq_q  <= (pp_q == 2'd0) ? pp_sh : sq_q + pp_sh;
    if (state_q == StNum && pp_q == 2'd3) begin
      p_q    <= '0;
      qd_q   <= '0;
      root_q <= '0;
    end
    if (state_q == StRoot && take) begin
      p_q    <= cand;
      qd_q   <= qd_q + (QW'(den_q) << bit_q);
      root_q <= root_try;
    end
    if (state_q == StDone && gend_q && out_free) max_cos_q <= run_max_q;
  end

  assign out_valid_o  = out_valid_q;
  assign max_cosine_o = max_cos_q;

  `TMAC_ASSERT_NEXT(a_pop_starts, q_pop_o, state_q == StMul, "pop did not start a triangle")
  `TMAC_ASSERT_NEXT(a_root_ends, state_q == StRoot && bit_q == 5'd0,
                    state_q == StCheck || state_q == StDone, "root loop overran")
  `TMAC_ASSERT_IMPL(a_word_src, $rose(out_valid_q), $past(state_q) == StDone,
                    "result word without finished group")
  `TMAC_ASSERT_IMPL(a_word_range, out_valid_q, max_cos_q <= tmac_pkg::OneQ16,
                    "result above 1.0")

endmodule

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB = 16;
  localparam int unsigned NUM_RANDOM = 1850;
  // allow for the slowest triangle in the back end and the longest input
  // gaps and output stalls on every word, several times over
  localparam longint unsigned CYCLE_LIMIT = 5000000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
    logic   group_end;
  } tri_word_t;

  logic clk_i;
  logic rst_ni;
  coord_t ax_i, ay_i, az_i, bx_i, by_i, bz_i, cx_i, cy_i, cz_i;
  logic group_end_i;
  logic in_valid_i;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i;
  logic [tmac_pkg::CosW-1:0] max_cosine_o;

  triangle_max_angle_cosine #(.COORD_BITS(CB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .ax_i(ax_i), .ay_i(ay_i), .az_i(az_i),
    .bx_i(bx_i), .by_i(by_i), .bz_i(bz_i),
    .cx_i(cx_i), .cy_i(cy_i), .cz_i(cz_i),
    .group_end_i(group_end_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .max_cosine_o(max_cosine_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  tri_word_t       pending_tris[$];
  logic [tmac_pkg::CosW-1:0] expected_max[$];
  logic [tmac_pkg::CosW-1:0] group_max;    // predictor copy of the running maximum
  int unsigned     n_errors;
  int unsigned     n_results;
  int unsigned     n_sent;
  int unsigned     n_degenerate;
  longint unsigned n_cycles;

  // floor(65536*|dot|/(|u||v|)) by bit search on q^2*nu*nv <= dot^2*2^32;
  // returns -1 for a corner with a zero-length edge
  function automatic int corner_q16(longint ux, longint uy, longint uz,
                                    longint vx, longint vy, longint vz);
    longint dot;
    logic [63:0] nu, nv, ad;
    logic [191:0] den, num, lhs;
    logic [33:0] q, t;
    dot = ux*vx + uy*vy + uz*vz;
    nu = ux*ux + uy*uy + uz*uz;
    nv = vx*vx + vy*vy + vz*vz;
    if (nu == 0 || nv == 0) return -1;
    ad = (dot < 0) ? -dot : dot;
    den = {128'd0, nu} * {128'd0, nv};
    num = ({128'd0, ad} * {128'd0, ad}) << 32;
    q = 0;
    for (int b = 16; b >= 0; b--) begin
      t = q | (34'd1 << b);
      lhs = {158'd0, t} * {158'd0, t} * den;
      if (lhs <= num) q = t;
    end
    if (q > 34'd65536) q = 34'd65536;
    return int'(q);
  endfunction

  task automatic predict_triangle(input tri_word_t w);
    longint l1[3], l2[3], l3[3];
    int c[3];
    bit any;
    l1[0] = longint'(w.bx) - w.ax; l1[1] = longint'(w.by) - w.ay;
    l1[2] = longint'(w.bz) - w.az;
    l2[0] = longint'(w.cx) - w.bx; l2[1] = longint'(w.cy) - w.by;
    l2[2] = longint'(w.cz) - w.bz;
    l3[0] = longint'(w.ax) - w.cx; l3[1] = longint'(w.ay) - w.cy;
    l3[2] = longint'(w.az) - w.cz;
    c[0] = corner_q16(l1[0], l1[1], l1[2], l3[0], l3[1], l3[2]);
    c[1] = corner_q16(l1[0], l1[1], l1[2], l2[0], l2[1], l2[2]);
    c[2] = corner_q16(l2[0], l2[1], l2[2], l3[0], l3[1], l3[2]);
    any = 0;
    foreach (c[k]) begin
      if (c[k] >= 0) any = 1;
      if (c[k] >= 0 && c[k] > group_max) group_max = c[k][tmac_pkg::CosW-1:0];
    end
    if (!any) n_degenerate++;
    if (w.group_end) begin
      expected_max.push_back(group_max);
      group_max = '0;
    end
  endtask

  function automatic int gap_len();
    // mostly back to back or short, now and then a long pause
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic coord_t rnd_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return coord_t'(16'h8000);
    if (r == 1) return coord_t'(16'h7fff);
    if (r < 5) return coord_t'($urandom_range(0, 64) - 32);
    return coord_t'($urandom());
  endfunction

  task automatic add_tri(input coord_t ax, ay, az, bx, by, bz, cx, cy, cz,
                         input logic ge);
    tri_word_t w;
    w = '{ax, ay, az, bx, by, bz, cx, cy, cz, ge};
    pending_tris.push_back(w);
  endtask

  // driver: valid and payload change only at the falling edge
  int unsigned in_gap;
  bit          in_hold_off;
  bit          in_taken;     // word accepted at the last rising edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_taken) begin
        void'(pending_tris.pop_front());
        n_sent++;
        in_gap = gap_len();
      end
      if (in_valid_i && !in_taken) begin
        // hold the stalled word
      end else if (in_gap > 0 || pending_tris.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid_i <= 1'b0;
      end else begin
        {ax_i, ay_i, az_i, bx_i, by_i, bz_i, cx_i, cy_i, cz_i, group_end_i}
          <= pending_tris[0];
        in_valid_i <= 1'b1;
      end
    end
  end

  // prediction happens on acceptance, sampled at the rising edge
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken)
      predict_triangle({ax_i, ay_i, az_i, bx_i, by_i, bz_i, cx_i, cy_i, cz_i,
                        group_end_i});
  end

  // receiver stall pattern, changed at the falling edge
  int unsigned stall_left;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = gap_len();
      out_stall_i <= (stall_left > 0);
    end
  end

  // monitor: compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_max.size() == 0) begin
        $display("%0t: unexpected result word, max_cosine=%0d", $time, max_cosine_o);
        n_errors++;
      end else begin
        if (max_cosine_o !== expected_max[0]) begin
          $display("%0t: max_cosine mismatch, expected %0d actual %0d", $time,
                   expected_max[0], max_cosine_o);
          n_errors++;
        end
        void'(expected_max.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               expected_max.size());
      $display("triangle_max_angle_cosine regression: fail");
      $finish;
    end
  end

  initial begin
    int glen;
    int k;
    coord_t m, x;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    {ax_i, ay_i, az_i, bx_i, by_i, bz_i, cx_i, cy_i, cz_i} = '0;
    group_end_i = 1'b0;
    group_max = '0;
    n_errors = 0; n_results = 0; n_sent = 0; n_degenerate = 0; n_cycles = 0;
    in_gap = 0; stall_left = 0;

    m = coord_t'(16'h8000);
    x = coord_t'(16'h7fff);
    // directed: right triangles, single-word groups
    add_tri(0, 0, 0, 10, 0, 0, 0, 10, 0, 1);
    add_tri(0, 0, 0, 3, 0, 0, 0, 4, 0, 1);
    // collinear points: cosine saturates at 1.0
    add_tri(0, 0, 0, 1, 1, 1, 2, 2, 2, 1);
    // extreme corners of the coordinate space
    add_tri(m, m, m, x, x, x, m, x, m, 1);
    add_tri(x, m, x, m, x, m, x, x, x, 1);
    add_tri(m, 0, 0, x, 0, 0, 0, x, 0, 1);
    add_tri(-1, -1, -1, 0, 0, 0, x, m, 1, 1);
    // zero-length edge: two equal vertices, one corner still counts
    add_tri(5, 5, 5, 5, 5, 5, 9, 1, -3, 1);
    // all vertices equal: every corner skipped, group gives 0
    add_tri(7, 7, 7, 7, 7, 7, 7, 7, 7, 1);
    add_tri(m, m, m, m, m, m, m, m, m, 1);
    // degenerate triangle inside a larger group leaves the maximum alone
    add_tri(0, 0, 0, 10, 0, 0, 0, 10, 0, 0);
    add_tri(3, 3, 3, 3, 3, 3, 3, 3, 3, 0);
    add_tri(0, 0, 0, 100, 1, 0, -100, 2, 0, 1);
    // maximum carries across a run of words until the group end
    add_tri(0, 0, 0, 4, 0, 0, 0, 4, 0, 0);
    add_tri(0, 0, 0, 4, 1, 0, 0, 4, 0, 0);
    add_tri(0, 0, 0, 1, 0, 0, 2, 1, 0, 0);
    add_tri(0, 0, 0, 9, 0, 0, 0, 0, 9, 1);
    add_tri(x, x, x, x, x, x, m, m, m, 1);

    // random groups, mostly short, some long
    k = 0;
    while (k < NUM_RANDOM) begin
      glen = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 20);
      for (int g = 0; g < glen; g++) begin
        if ($urandom_range(0, 19) == 0)
          add_tri(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), g == glen - 1);
        else begin
          coord_t p0, p1, p2;
          p0 = rnd_coord(); p1 = rnd_coord(); p2 = rnd_coord();
          // occasionally repeat a vertex to hit zero-length edges
          if ($urandom_range(0, 14) == 0)
            add_tri(p0, p1, p2, p0, p1, p2, rnd_coord(), rnd_coord(), rnd_coord(),
                    g == glen - 1);
          else
            add_tri(p0, p1, p2, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                    rnd_coord(), rnd_coord(), g == glen - 1);
        end
        k++;
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_tris.size() == 0 && !in_valid_i);
    wait (expected_max.size() == 0);
    // drain: let the design settle before the summary
    repeat (300) @(posedge clk_i);

    $display("sent %0d triangle words (%0d with no usable corner), checked %0d maxima",
             n_sent, n_degenerate, n_results);
    $display("groups of 1 to 20 triangles, random input gaps and output stalls");
    if (n_errors == 0 && expected_max.size() == 0) begin
      $display("triangle_max_angle_cosine regression: pass");
    end else begin
      $display("triangle_max_angle_cosine regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/tmac_pkg.sv
rtl/tmac_front.sv
rtl/tmac_queue.sv
rtl/tmac_back.sv
rtl/triangle_max_angle_cosine.sv
sim/tb_top.sv
